/* hw/rtl/cla_pkg.sv */
`default_nettype none

package cla_pkg;

    // Number formats
    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 14;
    localparam int OUT_BITS    = 16;
    localparam int PROD_BITS   = 2 * OUT_BITS;
    localparam int RAW_BITS    = PROD_BITS + 1;

    // Normalizer datapath widths
    localparam int M_BITS     = 20;
    localparam int SQ_BITS    = 2 * M_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int X_BITS     = 62;
    localparam int K_BITS     = 5;
    localparam int ROOT_BITS  = X_BITS / 2;
    localparam int ISQ_STAGES = X_BITS / 2;
    localparam int Q_BITS     = FRAC_BITS + 1;
    localparam int NUM_BITS   = ROOT_BITS + Q_BITS;
    localparam int PRE_STAGES = 7;
    localparam int NORM_LAT   = PRE_STAGES + ISQ_STAGES + 1 + Q_BITS + 1;

    localparam logic [63:0] OUT_MAG = 64'd1 << (OUT_BITS - 1);
    localparam logic [63:0] RIGHT_THRESH = (64'd1 << (4 * FRAC_BITS)) / 64'd100000000;

    localparam logic [OUT_BITS-1:0] UP_X_RESET = OUT_BITS'(0);
    localparam logic [OUT_BITS-1:0] UP_Y_RESET = OUT_BITS'(1 << FRAC_BITS);
    localparam logic [OUT_BITS-1:0] UP_Z_RESET = OUT_BITS'(0);

    typedef enum logic [1:0] {
        CFG_UP_X = 2'd0,
        CFG_UP_Y = 2'd1,
        CFG_UP_Z = 2'd2
    } cfg_idx_t;

    // Three fixed-point components, index 0 is x.
    typedef logic [2:0][OUT_BITS-1:0] vec_t;

    // Per-item side information of the normalizer.
    typedef struct packed {
        logic [2:0] neg;
        logic       ne;
        vec_t       rnd;
    } nflag_t;

    // Rounds a magnitude with 2*FRAC_BITS fraction bits half up to FRAC_BITS,
    // restores the sign and saturates to the output range.
    function automatic logic [OUT_BITS-1:0] sat_round(input logic [63:0] mag_in,
                                                      input logic neg);
        logic [63:0] t;
        logic [OUT_BITS-1:0] res;
        t = (mag_in + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (neg) begin
            if (t >= OUT_MAG) res = {1'b1, {(OUT_BITS-1){1'b0}}};
            else res = OUT_BITS'(64'd0 - t);
        end else begin
            if (t >= OUT_MAG) res = {1'b0, {(OUT_BITS-1){1'b1}}};
            else res = OUT_BITS'(t);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cla_delay.sv */
`default_nettype none

module cla_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] d,
    output logic      [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++) tap_reg[i] <= '0;
        end
        else if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

/* hw/rtl/cla_isqrt.sv */
`default_nettype none

// Pipelined integer square root, one result bit per stage.
module cla_isqrt (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic [cla_pkg::X_BITS-1:0]     x,
    output logic      [cla_pkg::ROOT_BITS-1:0]  root
);

    localparam int N = cla_pkg::ISQ_STAGES;
    localparam int W = cla_pkg::X_BITS + 1;

    logic [W-1:0] rem_reg [N-1];
    logic [W-1:0] acc_reg [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam int SH = 2 * (N - 1 - g);
        logic [W-1:0] rem_in;
        logic [W-1:0] acc_in;
        logic [W-1:0] trial;

        if (g == 0) begin : g_first
            assign rem_in = W'(x);
            assign acc_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[g-1];
            assign acc_in = acc_reg[g-1];
        end

        assign trial = acc_in + (W'(1) << SH);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial) acc_reg[g] <= (acc_in >> 1) + (W'(1) << SH);
                else acc_reg[g] <= acc_in >> 1;
            end
        end

        if (g < N - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rem_in >= trial) rem_reg[g] <= rem_in - trial;
                    else rem_reg[g] <= rem_in;
                end
            end
        end
    end

    assign root = acc_reg[N-1][cla_pkg::ROOT_BITS-1:0];

endmodule

`default_nettype wire

/* hw/rtl/cla_div.sv */
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage. The numerator
// must be below den * 2^Q_BITS.
module cla_div (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic [cla_pkg::NUM_BITS-1:0]   num,
    input  wire logic [cla_pkg::ROOT_BITS-1:0]  den,
    output logic      [cla_pkg::Q_BITS-1:0]     quo
);

    localparam int N  = cla_pkg::Q_BITS;
    localparam int NW = cla_pkg::NUM_BITS;

    logic [NW-1:0]                    rem_reg [N-1];
    logic [cla_pkg::ROOT_BITS-1:0]    den_reg [N-1];
    logic [N-1:0]                     quo_reg [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam int J = N - 1 - g;
        logic [NW-1:0]                 rem_in;
        logic [cla_pkg::ROOT_BITS-1:0] den_in;
        logic [N-1:0]                  quo_in;
        logic [NW-1:0]                 sub;

        if (g == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[g-1];
            assign den_in = den_reg[g-1];
            assign quo_in = quo_reg[g-1];
        end

        assign sub = NW'(den_in) << J;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= sub) quo_reg[g] <= quo_in | (N'(1) << J);
                else quo_reg[g] <= quo_in;
            end
        end

        if (g < N - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[g] <= den_in;
                    if (rem_in >= sub) rem_reg[g] <= rem_in - sub;
                    else rem_reg[g] <= rem_in;
                end
            end
        end
    end

    assign quo = quo_reg[N-1];

endmodule

`default_nettype wire

/* hw/rtl/cla_norm.sv */
`default_nettype none

// Vector normalizer. When norm_in is low the input is only rounded to
// FRAC_BITS fraction bits and saturated.
module cla_norm #(
    parameter int IW = 17,
    parameter int SW = 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic [2:0][IW-1:0]    vin,
    input  wire logic                  norm_in,
    input  wire logic [SW-1:0]         side_in,
    output cla_pkg::vec_t              vout,
    output logic      [SW-1:0]         side_out
);

    localparam int S_BITS  = $clog2(IW + 1);
    localparam int MB      = cla_pkg::M_BITS;
    localparam int MK_BITS = 3 * MB + cla_pkg::K_BITS;
    localparam int FL_BITS = $bits(cla_pkg::nflag_t);

    logic [IW-1:0]               mag1_reg [3];
    logic [IW-1:0]               mag2_reg [3];
    logic [IW-1:0]               mag3_reg [3];
    logic [IW-1:0]               mx2_reg;
    logic [S_BITS-1:0]           s3_reg;
    logic [2:0][MB-1:0]          m4_reg, m5_reg, m6_reg, m7_reg;
    logic [cla_pkg::SQ_BITS-1:0] sq5_reg [3];
    logic [cla_pkg::SUM_BITS-1:0] sum6_reg;
    logic [cla_pkg::X_BITS-1:0]  x7_reg;
    logic [cla_pkg::K_BITS-1:0]  k7_reg;
    cla_pkg::nflag_t             fl1_reg, fl2_reg, fl3_reg, fl4_reg, fl5_reg, fl6_reg, fl7_reg;

    cla_pkg::nflag_t             fl1_next;
    logic [IW-1:0]               mag1_next [3];
    logic [S_BITS-1:0]           s3_next;
    logic [cla_pkg::K_BITS-1:0]  k7_next;

    logic [cla_pkg::ROOT_BITS-1:0] root;
    logic [MK_BITS-1:0]          mk_d;
    logic [FL_BITS-1:0]          fl_d_bits;
    cla_pkg::nflag_t             fl_d;
    logic [2:0][MB-1:0]          m_d;
    logic [cla_pkg::K_BITS-1:0]  k_d;
    logic [cla_pkg::NUM_BITS-1:0] num_reg [3];
    logic [cla_pkg::ROOT_BITS-1:0] den_reg;
    logic [cla_pkg::Q_BITS-1:0]  quo [3];
    cla_pkg::vec_t               out_reg;

    // Stage 1: magnitudes, signs and the rounded fallback result.
    always_comb
    begin
        fl1_next.ne = norm_in;
        for (int i = 0; i < 3; i++)
        begin
            fl1_next.neg[i] = vin[i][IW-1];
            mag1_next[i] = vin[i][IW-1] ? IW'(-vin[i]) : vin[i];
            fl1_next.rnd[i] = cla_pkg::sat_round(64'(mag1_next[i]), vin[i][IW-1]);
        end
    end

    // Stage 3: shift that brings the largest magnitude below 2^M_BITS.
    always_comb
    begin
        logic [S_BITS-1:0] blen;
        blen = '0;
        for (int i = 0; i < IW; i++) if (mx2_reg[i]) blen = S_BITS'(i + 1);
        if (int'(blen) > MB) s3_next = S_BITS'(int'(blen) - MB);
        else s3_next = '0;
    end

    // Stage 7: scale the square sum by 4^k to fill the root's input range.
    always_comb
    begin
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < cla_pkg::SUM_BITS; i++) if (sum6_reg[i]) p = 6'(i);
        k7_next = cla_pkg::K_BITS'((7'(cla_pkg::X_BITS - 1) - 7'(p)) >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fl1_reg <= fl1_next;
            fl2_reg <= fl1_reg;
            fl3_reg <= fl2_reg;
            fl4_reg <= fl3_reg;
            fl5_reg <= fl4_reg;
            fl6_reg <= fl5_reg;
            fl7_reg <= fl6_reg;
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= mag1_next[i];
                mag2_reg[i] <= mag1_reg[i];
                mag3_reg[i] <= mag2_reg[i];
                m4_reg[i]   <= MB'(mag3_reg[i] >> s3_reg);
                sq5_reg[i]  <= cla_pkg::SQ_BITS'(m4_reg[i]) * cla_pkg::SQ_BITS'(m4_reg[i]);
            end
            if (mag1_reg[0] >= mag1_reg[1] && mag1_reg[0] >= mag1_reg[2]) mx2_reg <= mag1_reg[0];
            else if (mag1_reg[1] >= mag1_reg[2]) mx2_reg <= mag1_reg[1];
            else mx2_reg <= mag1_reg[2];
            s3_reg   <= s3_next;
            m5_reg   <= m4_reg;
            m6_reg   <= m5_reg;
            m7_reg   <= m6_reg;
            sum6_reg <= cla_pkg::SUM_BITS'(sq5_reg[0]) + cla_pkg::SUM_BITS'(sq5_reg[1])
                      + cla_pkg::SUM_BITS'(sq5_reg[2]);
            k7_reg   <= k7_next;
            x7_reg   <= cla_pkg::X_BITS'(64'(sum6_reg) << {k7_next, 1'b0});
        end
    end

    cla_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .x    (x7_reg),
        .root (root)
    );

    cla_delay #(.WIDTH(MK_BITS), .DEPTH(cla_pkg::ISQ_STAGES)) u_mk_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     ({m7_reg, k7_reg}),
        .q     (mk_d)
    );

    assign m_d = mk_d[MK_BITS-1:cla_pkg::K_BITS];
    assign k_d = mk_d[cla_pkg::K_BITS-1:0];

    // Numerator carries the half-divisor so the quotient rounds half up.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= root;
            for (int i = 0; i < 3; i++)
                num_reg[i] <= cla_pkg::NUM_BITS'((64'(m_d[i]) << (cla_pkg::FRAC_BITS + int'(k_d)))
                              + 64'(root >> 1));
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        cla_div u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[l]),
            .den (den_reg),
            .quo (quo[l])
        );
    end

    cla_delay #(.WIDTH(FL_BITS), .DEPTH(cla_pkg::ISQ_STAGES + 1 + cla_pkg::Q_BITS)) u_fl_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (fl7_reg),
        .q     (fl_d_bits)
    );

    assign fl_d = cla_pkg::nflag_t'(fl_d_bits);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (!fl_d.ne) out_reg[i] <= fl_d.rnd[i];
                else if (fl_d.neg[i]) out_reg[i] <= cla_pkg::OUT_BITS'(-quo[i]);
                else out_reg[i] <= cla_pkg::OUT_BITS'(quo[i]);
            end
        end
    end

    assign vout = out_reg;

    cla_delay #(.WIDTH(SW), .DEPTH(cla_pkg::NORM_LAT)) u_side_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (side_in),
        .q     (side_out)
    );

endmodule

`default_nettype wire

/* hw/rtl/camera_look_at_basis.sv */
// Throughput: one word per cycle; the two 31-stage square roots and 15-stage dividers are
// fully pipelined. The pipeline holds only when its last stage and the output register
// are both full and the output is stalled.
// Reset clears all valid bits and sets the world up vector to (0, 1.0, 0).
`default_nettype none

module camera_look_at_basis #(
    parameter int COORD_WIDTH = cla_pkg::COORD_WIDTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_addr,
    input  wire logic [cla_pkg::OUT_BITS-1:0]  cfg_wdata,
    // Input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [COORD_WIDTH-1:0] camera_x,
    input  wire logic signed [COORD_WIDTH-1:0] camera_y,
    input  wire logic signed [COORD_WIDTH-1:0] camera_z,
    input  wire logic signed [COORD_WIDTH-1:0] target_x,
    input  wire logic signed [COORD_WIDTH-1:0] target_y,
    input  wire logic signed [COORD_WIDTH-1:0] target_z,
    // Output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [cla_pkg::OUT_BITS-1:0] right_x,
    output logic signed [cla_pkg::OUT_BITS-1:0] right_y,
    output logic signed [cla_pkg::OUT_BITS-1:0] right_z,
    output logic signed [cla_pkg::OUT_BITS-1:0] upvec_x,
    output logic signed [cla_pkg::OUT_BITS-1:0] upvec_y,
    output logic signed [cla_pkg::OUT_BITS-1:0] upvec_z,
    output logic signed [cla_pkg::OUT_BITS-1:0] forward_x,
    output logic signed [cla_pkg::OUT_BITS-1:0] forward_y,
    output logic signed [cla_pkg::OUT_BITS-1:0] forward_z
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int OB  = cla_pkg::OUT_BITS;
    localparam int PB  = cla_pkg::PROD_BITS;
    localparam int RB  = cla_pkg::RAW_BITS;
    localparam int ONE = 1 << cla_pkg::FRAC_BITS;
    localparam int VW  = $bits(cla_pkg::vec_t);

    // The whole pipeline moves together. It advances whenever its last
    // stage is empty or the output register can take that stage's word,
    // so new words keep entering while a finished result waits.
    logic en;
    logic d3_v_reg;
    logic out_valid_reg;

    assign en       = !d3_v_reg || !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // World up vector registers.
    logic [OB-1:0] up_x_reg, up_y_reg, up_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_x_reg <= cla_pkg::UP_X_RESET;
            up_y_reg <= cla_pkg::UP_Y_RESET;
            up_z_reg <= cla_pkg::UP_Z_RESET;
        end
        else if (cfg_we)
        begin
            case (cla_pkg::cfg_idx_t'(cfg_addr))
                cla_pkg::CFG_UP_X: up_x_reg <= cfg_wdata;
                cla_pkg::CFG_UP_Y: up_y_reg <= cfg_wdata;
                cla_pkg::CFG_UP_Z: up_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input stage: the direction vector target minus camera.
    logic                  p0_v_reg;
    logic [2:0][DW-1:0]    d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) p0_v_reg <= 1'b0;
        else if (en) p0_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= DW'(target_x) - DW'(camera_x);
            d_reg[1] <= DW'(target_y) - DW'(camera_y);
            d_reg[2] <= DW'(target_z) - DW'(camera_z);
        end
    end

    // Forward vector. A zero direction is passed through the rounding path,
    // which yields the zero vector.
    cla_pkg::vec_t n1_f;
    logic          n1_v;

    cla_norm #(.IW(DW), .SW(1)) u_norm_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (d_reg),
        .norm_in  (|d_reg),
        .side_in  (p0_v_reg),
        .vout     (n1_f),
        .side_out (n1_v)
    );

    // Right vector, raw: forward cross world up, with 2*FRAC_BITS fraction bits.
    logic                  c1_v_reg, c2_v_reg, c3_v_reg, c4_v_reg;
    cla_pkg::vec_t         c1_f_reg, c2_f_reg, c3_f_reg, c4_f_reg;
    logic signed [PB-1:0]  c1_p_reg [6];
    logic signed [RB-1:0]  c2_rr_reg [3];
    logic signed [RB-1:0]  c3_rr_reg [3];
    logic [63:0]           c3_sq_reg [3];
    logic [2:0][RB-1:0]    c4_rr_reg;
    logic                  c4_ne_reg;
    logic [PB-1:0]         rr_mag [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            rr_mag[i] = c2_rr_reg[i][RB-1] ? PB'(-c2_rr_reg[i]) : PB'(c2_rr_reg[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_v_reg <= 1'b0;
            c2_v_reg <= 1'b0;
            c3_v_reg <= 1'b0;
            c4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_v_reg <= n1_v;
            c2_v_reg <= c1_v_reg;
            c3_v_reg <= c2_v_reg;
            c4_v_reg <= c3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_f_reg <= n1_f;
            c2_f_reg <= c1_f_reg;
            c3_f_reg <= c2_f_reg;
            c4_f_reg <= c3_f_reg;
            c1_p_reg[0] <= PB'($signed(n1_f[1])) * PB'($signed(up_z_reg));
            c1_p_reg[1] <= PB'($signed(n1_f[2])) * PB'($signed(up_y_reg));
            c1_p_reg[2] <= PB'($signed(n1_f[2])) * PB'($signed(up_x_reg));
            c1_p_reg[3] <= PB'($signed(n1_f[0])) * PB'($signed(up_z_reg));
            c1_p_reg[4] <= PB'($signed(n1_f[0])) * PB'($signed(up_y_reg));
            c1_p_reg[5] <= PB'($signed(n1_f[1])) * PB'($signed(up_x_reg));
            c2_rr_reg[0] <= RB'(c1_p_reg[0]) - RB'(c1_p_reg[1]);
            c2_rr_reg[1] <= RB'(c1_p_reg[2]) - RB'(c1_p_reg[3]);
            c2_rr_reg[2] <= RB'(c1_p_reg[4]) - RB'(c1_p_reg[5]);
            for (int i = 0; i < 3; i++)
            begin
                c3_rr_reg[i] <= c2_rr_reg[i];
                c3_sq_reg[i] <= 64'(rr_mag[i]) * 64'(rr_mag[i]);
                c4_rr_reg[i] <= c3_rr_reg[i];
            end
            // Squared length against the squared threshold.
            c4_ne_reg <= (c3_sq_reg[0] + c3_sq_reg[1] + c3_sq_reg[2]) > cla_pkg::RIGHT_THRESH;
        end
    end

    // Right vector, normalized or rounded; forward rides along.
    cla_pkg::vec_t      n2_r;
    cla_pkg::vec_t      n2_f;
    logic               n2_v;
    logic [VW:0]        n2_side;

    cla_norm #(.IW(RB), .SW(VW + 1)) u_norm_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (c4_rr_reg),
        .norm_in  (c4_ne_reg),
        .side_in  ({c4_v_reg, c4_f_reg}),
        .vout     (n2_r),
        .side_out (n2_side)
    );

    assign n2_v = n2_side[VW];
    assign n2_f = cla_pkg::vec_t'(n2_side[VW-1:0]);

    // Camera up: right cross forward, rounded back to FRAC_BITS.
    logic                  d1_v_reg, d2_v_reg;
    cla_pkg::vec_t         d1_r_reg, d2_r_reg, d3_r_reg;
    cla_pkg::vec_t         d1_f_reg, d2_f_reg, d3_f_reg;
    logic signed [PB-1:0]  d1_p_reg [6];
    logic signed [RB-1:0]  d2_u_reg [3];
    cla_pkg::vec_t         d3_u_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_v_reg <= 1'b0;
            d2_v_reg <= 1'b0;
            d3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            d1_v_reg <= n2_v;
            d2_v_reg <= d1_v_reg;
            d3_v_reg <= d2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_r_reg <= n2_r;
            d2_r_reg <= d1_r_reg;
            d3_r_reg <= d2_r_reg;
            d1_f_reg <= n2_f;
            d2_f_reg <= d1_f_reg;
            d3_f_reg <= d2_f_reg;
            d1_p_reg[0] <= PB'($signed(n2_r[1])) * PB'($signed(n2_f[2]));
            d1_p_reg[1] <= PB'($signed(n2_r[2])) * PB'($signed(n2_f[1]));
            d1_p_reg[2] <= PB'($signed(n2_r[2])) * PB'($signed(n2_f[0]));
            d1_p_reg[3] <= PB'($signed(n2_r[0])) * PB'($signed(n2_f[2]));
            d1_p_reg[4] <= PB'($signed(n2_r[0])) * PB'($signed(n2_f[1]));
            d1_p_reg[5] <= PB'($signed(n2_r[1])) * PB'($signed(n2_f[0]));
            d2_u_reg[0] <= RB'(d1_p_reg[0]) - RB'(d1_p_reg[1]);
            d2_u_reg[1] <= RB'(d1_p_reg[2]) - RB'(d1_p_reg[3]);
            d2_u_reg[2] <= RB'(d1_p_reg[4]) - RB'(d1_p_reg[5]);
            for (int i = 0; i < 3; i++)
                d3_u_reg[i] <= cla_pkg::sat_round(
                    d2_u_reg[i][RB-1] ? 64'(-d2_u_reg[i]) : 64'(d2_u_reg[i]),
                    d2_u_reg[i][RB-1]);
        end
    end

    // Output register: takes the last stage's word whenever it is free or
    // its current word is being taken.
    cla_pkg::vec_t out_r_reg, out_u_reg, out_f_reg;
    logic          out_load;

    assign out_load = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else if (out_load) out_valid_reg <= d3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_r_reg <= d3_r_reg;
            out_u_reg <= d3_u_reg;
            out_f_reg <= d3_f_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign right_x   = out_r_reg[0];
    assign right_y   = out_r_reg[1];
    assign right_z   = out_r_reg[2];
    assign upvec_x   = out_u_reg[0];
    assign upvec_y   = out_u_reg[1];
    assign upvec_z   = out_u_reg[2];
    assign forward_x = out_f_reg[0];
    assign forward_y = out_f_reg[1];
    assign forward_z = out_f_reg[2];

    // The input is held back only by a full, stalled output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled output word");

    // A normalized or zero forward vector never exceeds unit length per component.
    a_fwd_range: assert property (@(posedge clk) disable iff (!rst_n)
        n1_v |-> (($signed(n1_f[0]) <= ONE) && ($signed(n1_f[0]) >= -ONE)
               && ($signed(n1_f[1]) <= ONE) && ($signed(n1_f[1]) >= -ONE)
               && ($signed(n1_f[2]) <= ONE) && ($signed(n1_f[2]) >= -ONE)))
        else $error("forward component out of unit range");

    // A word leaving the last stage always lands in the output register.
    a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (d3_v_reg && en) |=> out_valid)
        else $error("word lost between last stage and output");

endmodule

`default_nettype wire
